FILE: src/rwcp_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk parser.
`timescale 1ns / 1ps
`default_nettype none
package rwcp_pkg;

  localparam logic [31:0] RIFF_MAGIC = 32'h5249_4646;
  localparam logic [31:0] WAVE_MAGIC = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT    = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA   = 32'h6461_7461;

  localparam logic [3:0] HEADER_LAST = 4'd11;
  localparam logic [3:0] CHUNK_LAST  = 4'd7;
  localparam logic [4:0] FMT_LEN     = 5'd16;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_NO_FMT     = 3'd2;
  localparam logic [2:0] ST_NO_DATA    = 3'd3;
  localparam logic [2:0] ST_NOT_PCM    = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef logic [15:0][7:0] fmt_t;

  typedef struct packed {
    logic       has_pl;
    logic [7:0] pl;
    logic       cs;
    logic       fin;
    logic [2:0] status;
    fmt_t       fmt;
  } q_entry_t;

  function automatic logic [7:0] magic_byte(input logic [31:0] m, input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = m[31:24];
      2'd1:    r = m[23:16];
      2'd2:    r = m[15:8];
      default: r = m[7:0];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/rwcp_front.sv
// Front end: header check, chunk walk, fmt shadows and per-item queue entry.
`timescale 1ns / 1ps
`default_nettype none
module rwcp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_is_final,
  output logic                   q_push,
  output rwcp_pkg::q_entry_t     q_entry
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_CHUNK  = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_SINK   = 2'd3;

  logic [1:0]     phase_r, phase_nxt;
  logic [3:0]     fc_r, fc_nxt;
  logic           hok_r, hok_nxt;
  logic [31:0]    tag_r, tag_nxt;
  logic [31:0]    len_r, len_nxt;
  logic [32:0]    bl_r, bl_nxt;
  logic [4:0]     bo_r, bo_nxt;
  logic [1:0]     live_r, live_nxt;
  logic [4:0]     pend0_r, pend0_nxt;
  logic [4:0]     pend1_r, pend1_nxt;
  rwcp_pkg::fmt_t sh0_r, sh0_nxt;
  rwcp_pkg::fmt_t sh1_r, sh1_nxt;
  rwcp_pkg::fmt_t com_r, com_nxt;
  logic           hf_r, hf_nxt;
  logic           hd_r, hd_nxt;

  logic           start_fmt;
  logic           has_pl;
  logic           cs;
  logic           real_byte;
  logic [2:0]     st;

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    hok_nxt   = hok_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    bl_nxt    = bl_r;
    bo_nxt    = bo_r;
    live_nxt  = live_r;
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    sh0_nxt   = sh0_r;
    sh1_nxt   = sh1_r;
    com_nxt   = com_r;
    hf_nxt    = hf_r;
    hd_nxt    = hd_r;
    start_fmt = 1'b0;
    has_pl    = 1'b0;
    cs        = 1'b0;
    real_byte = 1'b0;
    st        = rwcp_pkg::ST_OK;

    case (phase_r)
      PH_HEADER: begin
        if (fc_r < 4'd4 &&
            in_byte != rwcp_pkg::magic_byte(rwcp_pkg::RIFF_MAGIC, fc_r[1:0]))
          hok_nxt = 1'b0;
        if (fc_r >= 4'd8 &&
            in_byte != rwcp_pkg::magic_byte(rwcp_pkg::WAVE_MAGIC, fc_r[1:0]))
          hok_nxt = 1'b0;
        fc_nxt = fc_r + 4'd1;
        if (fc_r == rwcp_pkg::HEADER_LAST) begin
          fc_nxt    = 4'd0;
          phase_nxt = hok_nxt ? PH_CHUNK : PH_SINK;
        end
      end
      PH_CHUNK: begin
        if (fc_r < 4'd4) tag_nxt = {tag_r[23:0], in_byte};
        else             len_nxt = {in_byte, len_r[31:8]};
        fc_nxt = fc_r + 4'd1;
        if (fc_r == rwcp_pkg::CHUNK_LAST) begin
          fc_nxt = 4'd0;
          bl_nxt = {1'b0, len_nxt} + 33'(len_nxt[0]);
          bo_nxt = 5'd0;
          if (tag_nxt == rwcp_pkg::TAG_DATA) hd_nxt = 1'b1;
          if (tag_nxt == rwcp_pkg::TAG_FMT) start_fmt = 1'b1;
          phase_nxt = (len_nxt != 32'd0) ? PH_BODY : PH_CHUNK;
        end
      end
      PH_BODY: begin
        real_byte = !(len_r[0] && bl_r == 33'd1);
        if (tag_r == rwcp_pkg::TAG_DATA && real_byte) begin
          has_pl = 1'b1;
          cs     = (bo_r == 5'd0);
        end
        if (tag_r == rwcp_pkg::TAG_FMT && bo_r < rwcp_pkg::FMT_LEN &&
            {27'd0, bo_r} < len_r && live_r != 2'd0) begin
          if (live_r == 2'd1) sh0_nxt[bo_r[3:0]] = in_byte;
          else                sh1_nxt[bo_r[3:0]] = in_byte;
        end
        if (bo_r < rwcp_pkg::FMT_LEN) bo_nxt = bo_r + 5'd1;
        bl_nxt = bl_r - 33'd1;
        if (bl_r == 33'd1) phase_nxt = PH_CHUNK;
      end
      default: begin
      end
    endcase

    // age pending shadows, commit the oldest
    if (live_r >= 2'd1 && pend0_r < rwcp_pkg::FMT_LEN) pend0_nxt = pend0_r + 5'd1;
    if (live_r >= 2'd2 && pend1_r < rwcp_pkg::FMT_LEN) pend1_nxt = pend1_r + 5'd1;
    if (live_r != 2'd0 && pend0_nxt >= rwcp_pkg::FMT_LEN) begin
      com_nxt   = sh0_nxt;
      hf_nxt    = 1'b1;
      sh0_nxt   = sh1_nxt;
      pend0_nxt = pend1_nxt;
      pend1_nxt = 5'd0;
      live_nxt  = live_r - 2'd1;
    end

    if (start_fmt) begin
      case (live_nxt)
        2'd0: begin
          sh0_nxt   = com_nxt;
          pend0_nxt = 5'd0;
        end
        2'd1: begin
          sh1_nxt   = sh0_nxt;
          pend1_nxt = 5'd0;
        end
        default: begin
          pend1_nxt = 5'd0;
        end
      endcase
      live_nxt = (live_nxt == 2'd0) ? 2'd1 : 2'd2;
    end

    if (phase_nxt == PH_HEADER || phase_nxt == PH_SINK || !hok_nxt)
      st = rwcp_pkg::ST_BAD_HEADER;
    else if (!hf_nxt)
      st = rwcp_pkg::ST_NO_FMT;
    else if (!hd_nxt)
      st = rwcp_pkg::ST_NO_DATA;
    else if ({com_nxt[1], com_nxt[0]} != 16'd1)
      st = rwcp_pkg::ST_NOT_PCM;
    else
      st = rwcp_pkg::ST_OK;
  end

  assign q_push         = accept && (has_pl || in_is_final);
  assign q_entry.has_pl = has_pl;
  assign q_entry.pl     = in_byte;
  assign q_entry.cs     = cs;
  assign q_entry.fin    = in_is_final;
  assign q_entry.status = st;
  assign q_entry.fmt    = com_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_is_final)) begin
      phase_r <= PH_HEADER;
      fc_r    <= 4'd0;
      hok_r   <= 1'b1;
      tag_r   <= 32'd0;
      len_r   <= 32'd0;
      bl_r    <= 33'd0;
      bo_r    <= 5'd0;
      live_r  <= 2'd0;
      pend0_r <= 5'd0;
      pend1_r <= 5'd0;
      sh0_r   <= '0;
      sh1_r   <= '0;
      com_r   <= '0;
      hf_r    <= 1'b0;
      hd_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      hok_r   <= hok_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      bl_r    <= bl_nxt;
      bo_r    <= bo_nxt;
      live_r  <= live_nxt;
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
      sh0_r   <= sh0_nxt;
      sh1_r   <= sh1_nxt;
      com_r   <= com_nxt;
      hf_r    <= hf_nxt;
      hd_r    <= hd_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/rwcp_queue.sv
// Small entry queue between the parser front end and the result back end.
`timescale 1ns / 1ps
`default_nettype none
module rwcp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire rwcp_pkg::q_entry_t  wdata,
  output logic                     full,
  input  wire logic                rd_en,
  output rwcp_pkg::q_entry_t       rdata,
  output logic                     empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  rwcp_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    if (!do_wr && do_rd) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == LAST) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == LAST) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/rwcp_back.sv
// Back end: expands queued entries into payload and status result items.
`timescale 1ns / 1ps
`default_nettype none
module rwcp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rwcp_pkg::q_entry_t  head,
  input  wire logic                q_empty,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     out_kind,
  output logic [7:0]               out_payload,
  output logic                     out_chunk_start,
  output logic [2:0]               out_status,
  output logic [15:0]              out_format_tag,
  output logic [15:0]              out_channels,
  output logic [31:0]              out_sample_rate,
  output logic [31:0]              out_byte_rate,
  output logic [15:0]              out_block_align,
  output logic [15:0]              out_sample_bits,
  output logic                     out_run_end
);

  logic part_r, part_nxt;
  logic is_pl;
  logic take;

  assign empty = q_empty;
  assign take  = pop && !q_empty;
  assign is_pl = head.has_pl && !part_r;
  assign q_pop = take && !(is_pl && head.fin);

  always_comb begin
    part_nxt = part_r;
    if (take) part_nxt = is_pl && head.fin;
  end

  always_comb begin
    out_kind        = is_pl ? rwcp_pkg::KIND_PAYLOAD : rwcp_pkg::KIND_STATUS;
    out_payload     = is_pl ? head.pl : 8'd0;
    out_chunk_start = is_pl && head.cs;
    out_run_end     = is_pl ? !head.fin : 1'b1;
    out_status      = is_pl ? rwcp_pkg::ST_OK : head.status;
    out_format_tag  = 16'd0;
    out_channels    = 16'd0;
    out_sample_rate = 32'd0;
    out_byte_rate   = 32'd0;
    out_block_align = 16'd0;
    out_sample_bits = 16'd0;
    if (!is_pl) begin
      out_format_tag  = {head.fmt[1], head.fmt[0]};
      out_channels    = {head.fmt[3], head.fmt[2]};
      out_sample_rate = {head.fmt[7], head.fmt[6], head.fmt[5], head.fmt[4]};
      out_byte_rate   = {head.fmt[11], head.fmt[10], head.fmt[9], head.fmt[8]};
      out_block_align = {head.fmt[13], head.fmt[12]};
      out_sample_bits = {head.fmt[15], head.fmt[14]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) part_r <= 1'b0;
    else        part_r <= part_nxt;
  end

endmodule
`default_nettype wire

FILE: src/riff_wave_chunk_parser.sv
// Top level of the RIFF/WAVE chunk parser.
// Takes one file byte per cycle and never stalls on its own: every byte that
// finds room is parsed in the cycle it is accepted. Data chunk bytes become one
// result each; the final byte adds a status result with the committed format
// fields, after the payload result of that byte if it has one. Results sit in a
// queue of QUEUE_DEPTH entries (one entry per byte that yields results); full
// rises when the queue holds QUEUE_DEPTH entries. Once the final byte is
// accepted the parser is back in its reset state and the next byte starts a
// new file.
`timescale 1ns / 1ps
`default_nettype none
module riff_wave_chunk_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_is_final,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_kind,
  output logic [7:0]       out_payload,
  output logic             out_chunk_start,
  output logic [2:0]       out_status,
  output logic [15:0]      out_format_tag,
  output logic [15:0]      out_channels,
  output logic [31:0]      out_sample_rate,
  output logic [31:0]      out_byte_rate,
  output logic [15:0]      out_block_align,
  output logic [15:0]      out_sample_bits,
  output logic             out_run_end
);

  logic               accept;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  rwcp_pkg::q_entry_t q_wdata;
  rwcp_pkg::q_entry_t q_head;

  assign accept = push && !full;

  rwcp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_is_final (in_is_final),
    .q_push      (q_push),
    .q_entry     (q_wdata)
  );

  rwcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wdata (q_wdata),
    .full  (full),
    .rd_en (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  rwcp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_payload     (out_payload),
    .out_chunk_start (out_chunk_start),
    .out_status      (out_status),
    .out_format_tag  (out_format_tag),
    .out_channels    (out_channels),
    .out_sample_rate (out_sample_rate),
    .out_byte_rate   (out_byte_rate),
    .out_block_align (out_block_align),
    .out_sample_bits (out_sample_bits),
    .out_run_end     (out_run_end)
  );

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for the RIFF/WAVE chunk parser: random WAV files against a predictor.
`timescale 1ns / 1ps
module tb;

  localparam logic [15:0] PCM_TAG = 16'h0001;

  typedef enum logic [1:0] {PH_HEADER, PH_CHUNK, PH_BODY, PH_SINK} parse_phase_t;
  typedef enum int {CK_FMT, CK_DATA, CK_OTHER, CK_NEAR_TAG} chunk_kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic        chunk_start;
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic        run_end;
  } wav_item_t;

  class wav_scoreboard;
    parse_phase_t     phase;
    logic [3:0]       field_count;
    logic             header_ok;
    logic [31:0]      chunk_tag;
    logic [31:0]      chunk_len;
    logic [32:0]      body_left;
    logic [4:0]       body_offset;
    int               fmt_live;
    logic [4:0]       fmt_pending [2];
    rwcp_pkg::fmt_t   fmt_shadow [2];
    rwcp_pkg::fmt_t   fmt_committed;
    logic             have_fmt;
    logic             have_data;
    wav_item_t        parsed_items [$];
    int               mismatches;
    int               checked;
    int               payload_count;
    int               status_tally [8];

    function new();
      restart();
      mismatches = 0;
      checked = 0;
      payload_count = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void restart();
      phase = PH_HEADER;
      field_count = '0;
      header_ok = 1'b1;
      chunk_tag = '0;
      chunk_len = '0;
      body_left = '0;
      body_offset = '0;
      fmt_live = 0;
      fmt_pending[0] = '0;
      fmt_pending[1] = '0;
      fmt_shadow[0] = '0;
      fmt_shadow[1] = '0;
      fmt_committed = '0;
      have_fmt = 1'b0;
      have_data = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      wav_item_t r;
      logic      start_fmt;
      logic      real_byte;
      int        idx;
      int        slot;
      start_fmt = 1'b0;
      idx = field_count;
      case (phase)
        PH_HEADER: begin
          if (idx < 4 && b != rwcp_pkg::RIFF_MAGIC[31 - 8 * idx -: 8]) header_ok = 1'b0;
          if (idx >= 8 && idx < 12 && b != rwcp_pkg::WAVE_MAGIC[95 - 8 * idx -: 8])
            header_ok = 1'b0;
          if (field_count == rwcp_pkg::HEADER_LAST) begin
            field_count = '0;
            if (header_ok) phase = PH_CHUNK;
            else phase = PH_SINK;
          end else begin
            field_count = field_count + 4'd1;
          end
        end
        PH_CHUNK: begin
          if (idx < 4) chunk_tag = {chunk_tag[23:0], b};
          else chunk_len = {b, chunk_len[31:8]};
          if (field_count == rwcp_pkg::CHUNK_LAST) begin
            field_count = '0;
            body_left = {1'b0, chunk_len} + {32'b0, chunk_len[0]};
            body_offset = '0;
            if (chunk_tag == rwcp_pkg::TAG_DATA) have_data = 1'b1;
            if (chunk_tag == rwcp_pkg::TAG_FMT) start_fmt = 1'b1;
            if (body_left != 0) phase = PH_BODY;
            else phase = PH_CHUNK;
          end else begin
            field_count = field_count + 4'd1;
          end
        end
        PH_BODY: begin
          real_byte = body_left > {32'b0, chunk_len[0]};
          if (chunk_tag == rwcp_pkg::TAG_DATA && real_byte) begin
            r = '0;
            r.kind = rwcp_pkg::KIND_PAYLOAD;
            r.payload = b;
            r.chunk_start = (body_offset == 5'd0);
            r.run_end = !fin;
            parsed_items.insert(parsed_items.size(), r);
          end
          if (chunk_tag == rwcp_pkg::TAG_FMT && body_offset < rwcp_pkg::FMT_LEN &&
              {27'b0, body_offset} < chunk_len && fmt_live > 0)
            fmt_shadow[fmt_live - 1][body_offset[3:0]] = b;
          if (body_offset < rwcp_pkg::FMT_LEN) body_offset = body_offset + 5'd1;
          body_left = body_left - 33'd1;
          if (body_left == 0) phase = PH_CHUNK;
        end
        default: ;
      endcase

      for (int i = 0; i < fmt_live && i < 2; i++)
        if (fmt_pending[i] < rwcp_pkg::FMT_LEN) fmt_pending[i] = fmt_pending[i] + 5'd1;
      if (fmt_live > 0 && fmt_pending[0] >= rwcp_pkg::FMT_LEN) begin
        fmt_committed = fmt_shadow[0];
        have_fmt = 1'b1;
        fmt_shadow[0] = fmt_shadow[1];
        fmt_pending[0] = fmt_pending[1];
        fmt_pending[1] = '0;
        fmt_live = fmt_live - 1;
      end

      // new fmt shadow starts from the newest pending one, else the committed one
      if (start_fmt) begin
        slot = (fmt_live < 2) ? fmt_live : 1;
        if (fmt_live == 0) fmt_shadow[slot] = fmt_committed;
        else if (slot != fmt_live - 1) fmt_shadow[slot] = fmt_shadow[fmt_live - 1];
        fmt_pending[slot] = '0;
        fmt_live = slot + 1;
      end

      if (fin) begin
        r = '0;
        r.kind = rwcp_pkg::KIND_STATUS;
        if (phase == PH_HEADER || phase == PH_SINK || !header_ok)
          r.status = rwcp_pkg::ST_BAD_HEADER;
        else if (!have_fmt) r.status = rwcp_pkg::ST_NO_FMT;
        else if (!have_data) r.status = rwcp_pkg::ST_NO_DATA;
        else if ({fmt_committed[1], fmt_committed[0]} != PCM_TAG)
          r.status = rwcp_pkg::ST_NOT_PCM;
        else r.status = rwcp_pkg::ST_OK;
        r.format_tag = {fmt_committed[1], fmt_committed[0]};
        r.channels = {fmt_committed[3], fmt_committed[2]};
        r.sample_rate = {fmt_committed[7], fmt_committed[6],
                         fmt_committed[5], fmt_committed[4]};
        r.byte_rate = {fmt_committed[11], fmt_committed[10],
                       fmt_committed[9], fmt_committed[8]};
        r.block_align = {fmt_committed[13], fmt_committed[12]};
        r.sample_bits = {fmt_committed[15], fmt_committed[14]};
        r.run_end = 1'b1;
        parsed_items.insert(parsed_items.size(), r);
        restart();
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_item(wav_item_t got);
      wav_item_t want;
      if (parsed_items.size() == 0) begin
        report($sformatf("result with nothing due (kind %0d, payload %02h)",
                         got.kind, got.payload));
        return;
      end
      want = parsed_items.pop_front();
      compare_field("kind", 32'(got.kind), 32'(want.kind));
      compare_field("payload", 32'(got.payload), 32'(want.payload));
      compare_field("chunk_start", 32'(got.chunk_start), 32'(want.chunk_start));
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("format_tag", 32'(got.format_tag), 32'(want.format_tag));
      compare_field("channels", 32'(got.channels), 32'(want.channels));
      compare_field("sample_rate", got.sample_rate, want.sample_rate);
      compare_field("byte_rate", got.byte_rate, want.byte_rate);
      compare_field("block_align", 32'(got.block_align), 32'(want.block_align));
      compare_field("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
      compare_field("run_end", 32'(got.run_end), 32'(want.run_end));
      if (want.kind == rwcp_pkg::KIND_STATUS) status_tally[want.status]++;
      else payload_count++;
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'h00;
  logic        in_is_final = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_kind;
  logic [7:0]  out_payload;
  logic        out_chunk_start;
  logic [2:0]  out_status;
  logic [15:0] out_format_tag;
  logic [15:0] out_channels;
  logic [31:0] out_sample_rate;
  logic [31:0] out_byte_rate;
  logic [15:0] out_block_align;
  logic [15:0] out_sample_bits;
  logic        out_run_end;

  riff_wave_chunk_parser uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .in_is_final(in_is_final),
    .empty(empty),
    .pop(pop),
    .out_kind(out_kind),
    .out_payload(out_payload),
    .out_chunk_start(out_chunk_start),
    .out_status(out_status),
    .out_format_tag(out_format_tag),
    .out_channels(out_channels),
    .out_sample_rate(out_sample_rate),
    .out_byte_rate(out_byte_rate),
    .out_block_align(out_block_align),
    .out_sample_bits(out_sample_bits),
    .out_run_end(out_run_end)
  );

  wav_scoreboard sb = new();
  logic [7:0]    file_bytes [$];
  wav_item_t     seen_item;
  int            bytes_sent = 0;
  int            files_sent = 0;
  bit            sender_calm = 1'b0;
  bit            receiver_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still due", sb.parsed_items.size());
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) sb.note_byte(in_byte, in_is_final);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      seen_item.kind = out_kind;
      seen_item.payload = out_payload;
      seen_item.chunk_start = out_chunk_start;
      seen_item.status = out_status;
      seen_item.format_tag = out_format_tag;
      seen_item.channels = out_channels;
      seen_item.sample_rate = out_sample_rate;
      seen_item.byte_rate = out_byte_rate;
      seen_item.block_align = out_block_align;
      seen_item.sample_bits = out_sample_bits;
      seen_item.run_end = out_run_end;
      sb.check_item(seen_item);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: bursts of pop with random stalls
  initial begin
    int burst;
    int g;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) receiver_calm = !receiver_calm;
      burst = $urandom_range(1, 12);
      pop <= 1'b1;
      repeat (burst) @(posedge clk);
      g = receiver_calm ? 0 : pick_gap();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    int g;
    g = sender_calm ? 0 : pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_is_final <= fin;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_file();
    int last;
    last = file_bytes.size() - 1;
    for (int i = 0; i <= last; i++) send_byte(file_bytes[i], i == last);
    files_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (sb.parsed_items.size() != 0);
  endtask

  function automatic void put_byte(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  function automatic void add_tag(logic [31:0] t);
    put_byte(t[31:24]);
    put_byte(t[23:16]);
    put_byte(t[15:8]);
    put_byte(t[7:0]);
  endfunction

  function automatic void add_le32(logic [31:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
    put_byte(v[23:16]);
    put_byte(v[31:24]);
  endfunction

  function automatic void add_noise(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // open_ended: declared size runs past end of file; brief: fmt body under 8 bytes
  function automatic void add_chunk(chunk_kind_t k, bit open_ended, bit brief);
    logic [31:0] tag;
    logic [31:0] size;
    logic [15:0] fmt_code;
    int          body_len;
    int          r;
    r = $urandom_range(0, 9);
    fmt_code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PCM_TAG;
    case (k)
      CK_FMT: begin
        tag = rwcp_pkg::TAG_FMT;
        if (brief) size = $urandom_range(0, 7);
        else if (r < 5) size = 16;
        else if (r == 5) size = 18;
        else if (r < 8) size = $urandom_range(0, 15);
        else if (r == 8) size = $urandom_range(17, 24);
        else size = 40;
      end
      CK_DATA: begin
        tag = rwcp_pkg::TAG_DATA;
        size = (r < 8) ? $urandom_range(0, 16) : $urandom_range(17, 60);
      end
      CK_OTHER: begin
        tag = $urandom;
        size = $urandom_range(0, 12);
      end
      default: begin
        tag = ($urandom_range(0, 1) ? rwcp_pkg::TAG_DATA : rwcp_pkg::TAG_FMT) ^
              (32'h1 << $urandom_range(0, 31));
        size = $urandom_range(0, 12);
      end
    endcase
    body_len = size;
    if (open_ended) begin
      r = $urandom_range(0, 2);
      size = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'hFFFF_FFFE : $urandom_range(100, 100000);
      body_len = $urandom_range(0, 20);
    end
    add_tag(tag);
    add_le32(size);
    for (int i = 0; i < body_len; i++) begin
      if (k == CK_FMT && i == 0) put_byte(fmt_code[7:0]);
      else if (k == CK_FMT && i == 1) put_byte(fmt_code[15:8]);
      else put_byte(8'($urandom_range(0, 255)));
    end
    if (!open_ended && size[0]) add_noise(1);
  endfunction

  function automatic void make_file();
    int style;
    int n;
    int idx;
    int cut;
    file_bytes.delete();
    style = $urandom_range(0, 99);
    if (style < 6) begin
      add_noise($urandom_range(1, 16));
      return;
    end
    add_tag(rwcp_pkg::RIFF_MAGIC);
    add_le32($urandom);
    add_tag(rwcp_pkg::WAVE_MAGIC);
    if (style < 14) begin
      idx = $urandom_range(0, 7);
      if (idx >= 4) idx += 4;
      file_bytes[idx] = file_bytes[idx] ^ (8'h1 << $urandom_range(0, 7));
    end
    if (style < 70) begin
      if ($urandom_range(0, 3) == 0) add_chunk(CK_OTHER, 1'b0, 1'b0);
      if ($urandom_range(0, 5) == 0) add_chunk(CK_FMT, 1'b0, 1'b1);
      add_chunk(CK_FMT, 1'b0, 1'b0);
      if ($urandom_range(0, 4) == 0) add_chunk(CK_OTHER, 1'b0, 1'b0);
      add_chunk(CK_DATA, 1'b0, 1'b0);
      n = $urandom_range(0, 2);
    end else begin
      n = $urandom_range(0, 5);
    end
    repeat (n) add_chunk(chunk_kind_t'($urandom_range(0, 3)), 1'b0, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) add_chunk(CK_DATA, 1'b1, 1'b0);
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // one-byte files, then a bare header plus an empty data chunk ending the file
    file_bytes.delete();
    put_byte(8'h00);
    send_file();
    file_bytes.delete();
    put_byte(8'hFF);
    send_file();
    file_bytes.delete();
    add_tag(rwcp_pkg::RIFF_MAGIC);
    add_le32(32'h00FF_00FF);
    add_tag(rwcp_pkg::WAVE_MAGIC);
    add_tag(rwcp_pkg::TAG_DATA);
    add_le32(32'h0);
    send_file();
    drain();

    while (bytes_sent < 1100) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      make_file();
      send_file();
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d files, %0d bytes in, %0d data bytes out",
             files_sent, bytes_sent, sb.payload_count);
    $display("status items: ok %0d, bad header %0d, no fmt %0d, no data %0d, not pcm %0d",
             sb.status_tally[rwcp_pkg::ST_OK], sb.status_tally[rwcp_pkg::ST_BAD_HEADER],
             sb.status_tally[rwcp_pkg::ST_NO_FMT], sb.status_tally[rwcp_pkg::ST_NO_DATA],
             sb.status_tally[rwcp_pkg::ST_NOT_PCM]);
    if (sb.mismatches == 0 && sb.parsed_items.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
